[rtl/lcar_pkg.sv]
// Shared constants and codes for the load-cell converter readout block.
package lcar_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int COUNT_W     = 8;
   localparam int SUM_W       = SAMPLE_BITS + COUNT_W;
   localparam int GAIN_W      = 2;
   localparam int OFS_W       = 24;
   localparam int VALUE_W     = 25;
   localparam int PULSE_W     = $clog2(SAMPLE_BITS + 1);
   localparam int OP_W        = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [OFS_W-1:0] OFS_MAX = '1;

   localparam logic [OP_W-1:0] OP_TICK       = 2'd0;
   localparam logic [OP_W-1:0] OP_MEASURE    = 2'd1;
   localparam logic [OP_W-1:0] OP_TARE       = 2'd2;
   localparam logic [OP_W-1:0] OP_SET_OFFSET = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_PULSES   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AVERAGE_COUNT = 2'd1;

   localparam logic [GAIN_W-1:0] GAIN_CHANNEL_A64 = 2'd3;

endpackage

[rtl/lcar_div.sv]
// Restoring divider that yields one quotient bit per cycle for the averaging step.
module lcar_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lcar_pkg::SUM_W-1:0]   dividend,
   input  logic [lcar_pkg::COUNT_W-1:0] divisor,
   output logic                         done,
   output logic [lcar_pkg::SUM_W-1:0]   quotient
);
   import lcar_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [COUNT_W-1:0]  rem_ff;
   logic [COUNT_W-1:0]  rem_in;
   logic [SUM_W-1:0]    quo_ff;
   logic [SUM_W-1:0]    quo_in;
   logic [COUNT_W-1:0]  div_ff;
   logic [COUNT_W:0]    rem_shift;
   logic [COUNT_W:0]    rem_diff;
   logic                fits;

   // The quotient register shifts the dividend out at the top while the
   // quotient bits enter at the bottom.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      fits      = rem_shift >= {1'b0, div_ff};
      rem_diff  = fits ? (rem_shift - {1'b0, div_ff}) : rem_shift;
      rem_in    = rem_diff[COUNT_W-1:0];
      quo_in    = {quo_ff[SUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == STEP_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         step_ff <= STEP_W'(SUM_W);
         rem_ff  <= '0;
         quo_ff  <= dividend;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         step_ff <= step_ff - STEP_W'(1);
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/load_cell_adc_reader.sv]
// Top level: tick sequencer for a two-wire load-cell converter with averaging and tare.
//
// Each transfer on the req channel is one tick of the converter pins and gives exactly one
// transfer on the rsp channel, held in an output register. The tick that ends a measure or
// tare run also starts the averaging divide: a restoring divider produces one quotient bit
// per cycle, so that tick's response appears only once the divide is done, and req_ready
// stays low meanwhile. The csr channel is always ready; index 0 writes gain_pulses, index 1
// writes average_count, and it is meant to be written only while no run is in progress.
module load_cell_adc_reader (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lcar_pkg::OP_W-1:0]        req_operation,
   input  logic                             req_dout_level,
   input  logic [lcar_pkg::OFS_W-1:0]       req_offset_value,
   input  logic                             req_offset_select,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_sck_level,
   output logic                             rsp_busy_res,
   output logic                             rsp_result_valid,
   output logic                             rsp_result_is_tare,
   output logic signed [lcar_pkg::VALUE_W-1:0] rsp_result_value,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lcar_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lcar_pkg::CSR_DATA_W-1:0]  csr_data
);
   import lcar_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WAIT,
      ST_DATA_HI,
      ST_DATA_LO,
      ST_GAIN_HI,
      ST_GAIN_LO,
      ST_DIVIDE
   } state_type;

   state_type            state_ff;
   logic [GAIN_W-1:0]    gain_pulses_ff;
   logic [COUNT_W-1:0]   average_count_ff;
   logic [PULSE_W-1:0]   pulse_count_ff;
   logic [SAMPLE_BITS-1:0] shift_data_ff;
   logic [SUM_W-1:0]     running_sum_ff;
   logic [COUNT_W-1:0]   reads_done_ff;
   logic                 run_is_tare_ff;
   logic                 use_a_ff;
   logic [OFS_W-1:0]     offset_a_ff;
   logic [OFS_W-1:0]     offset_b_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_sck_ff;
   logic                 rsp_busy_ff;
   logic                 rsp_result_valid_ff;
   logic                 rsp_is_tare_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;

   logic                 req_fire;
   logic                 csr_fire;
   logic [GAIN_W-1:0]    eff_gain;
   logic [COUNT_W-1:0]   eff_count;
   logic                 gain_done;
   logic [SUM_W-1:0]     sum_in;
   logic [COUNT_W-1:0]   reads_in;
   logic                 run_done;
   logic                 div_start;
   logic                 div_done;
   logic [SUM_W-1:0]     avg;
   logic [OFS_W-1:0]     active_ofs;
   logic [OFS_W-1:0]     tare_value;
   logic signed [SUM_W:0] diff;
   logic [VALUE_W-1:0]   measure_value;
   logic [VALUE_W-1:0]   final_value;

   localparam logic signed [SUM_W:0] DIFF_MAX = {{(SUM_W + 1 - OFS_W){1'b0}}, OFS_MAX};

   assign req_ready = (state_ff != ST_DIVIDE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;

   always_comb begin
      eff_gain  = (gain_pulses_ff == '0) ? GAIN_W'(1) : gain_pulses_ff;
      eff_count = (average_count_ff == '0) ? COUNT_W'(1) : average_count_ff;
      gain_done = pulse_count_ff >= PULSE_W'(eff_gain);
      // Flipping the top bit turns the two's complement sample into offset binary.
      sum_in    = running_sum_ff + SUM_W'({~shift_data_ff[SAMPLE_BITS-1],
                                           shift_data_ff[SAMPLE_BITS-2:0]});
      reads_in  = reads_done_ff + COUNT_W'(1);
      if (reads_in == '0) begin
         reads_in = COUNT_W'(1);
      end
      run_done  = reads_in >= eff_count;
      div_start = req_fire && state_ff == ST_GAIN_LO && gain_done && run_done;
   end

   lcar_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (reads_in),
      .done     (div_done),
      .quotient (avg)
   );

   always_comb begin
      active_ofs = use_a_ff ? offset_a_ff : offset_b_ff;
      tare_value = (avg > {{(SUM_W - OFS_W){1'b0}}, OFS_MAX}) ? OFS_MAX : avg[OFS_W-1:0];
      diff       = $signed({1'b0, avg}) -
                   $signed({{(SUM_W + 1 - OFS_W){1'b0}}, active_ofs});
      measure_value = (diff > DIFF_MAX) ? VALUE_W'(OFS_MAX) : diff[VALUE_W-1:0];
      final_value   = run_is_tare_ff ? {1'b0, tare_value} : measure_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         gain_pulses_ff   <= GAIN_W'(1);
         average_count_ff <= COUNT_W'(1);
         pulse_count_ff   <= '0;
         shift_data_ff    <= '0;
         running_sum_ff   <= '0;
         reads_done_ff    <= '0;
         run_is_tare_ff   <= 1'b0;
         use_a_ff         <= 1'b0;
         offset_a_ff      <= '0;
         offset_b_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_fire) begin
            case (csr_index)
               CSR_GAIN_PULSES:   gain_pulses_ff   <= csr_data[GAIN_W-1:0];
               CSR_AVERAGE_COUNT: average_count_ff <= csr_data[COUNT_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_ready && !req_fire) begin
            rsp_valid_ff <= 1'b0;
         end

         if (req_fire) begin
            rsp_valid_ff        <= !div_start;
            rsp_sck_ff          <= (state_ff == ST_DATA_HI) || (state_ff == ST_GAIN_HI);
            rsp_busy_ff         <= 1'b1;
            rsp_result_valid_ff <= 1'b0;
            rsp_is_tare_ff      <= 1'b0;
            rsp_value_ff        <= '0;
            case (state_ff)
               ST_IDLE: begin
                  if (req_operation == OP_MEASURE || req_operation == OP_TARE) begin
                     run_is_tare_ff <= (req_operation == OP_TARE);
                     running_sum_ff <= '0;
                     reads_done_ff  <= '0;
                     pulse_count_ff <= '0;
                     state_ff       <= ST_WAIT;
                  end else begin
                     rsp_busy_ff <= 1'b0;
                     if (req_operation == OP_SET_OFFSET) begin
                        if (req_offset_select) begin
                           offset_b_ff <= req_offset_value;
                        end else begin
                           offset_a_ff <= req_offset_value;
                        end
                     end
                  end
               end
               ST_WAIT: begin
                  if (!req_dout_level) begin
                     pulse_count_ff <= '0;
                     shift_data_ff  <= '0;
                     state_ff       <= ST_DATA_HI;
                  end
               end
               ST_DATA_HI: begin
                  shift_data_ff  <= {shift_data_ff[SAMPLE_BITS-2:0], req_dout_level};
                  pulse_count_ff <= pulse_count_ff + PULSE_W'(1);
                  state_ff       <= ST_DATA_LO;
               end
               ST_DATA_LO: begin
                  if (pulse_count_ff >= PULSE_W'(SAMPLE_BITS)) begin
                     pulse_count_ff <= '0;
                     state_ff       <= ST_GAIN_HI;
                  end else begin
                     state_ff <= ST_DATA_HI;
                  end
               end
               ST_GAIN_HI: begin
                  pulse_count_ff <= pulse_count_ff + PULSE_W'(1);
                  state_ff       <= ST_GAIN_LO;
               end
               ST_GAIN_LO: begin
                  if (!gain_done) begin
                     state_ff <= ST_GAIN_HI;
                  end else begin
                     pulse_count_ff <= '0;
                     running_sum_ff <= sum_in;
                     reads_done_ff  <= reads_in;
                     if (run_done) begin
                        use_a_ff <= (eff_gain == GAIN_CHANNEL_A64);
                        state_ff <= ST_DIVIDE;
                     end else begin
                        state_ff <= ST_WAIT;
                     end
                  end
               end
               default: ;
            endcase
         end

         // The finishing tick's response is produced once the average is known.
         if (div_done) begin
            rsp_valid_ff        <= 1'b1;
            rsp_sck_ff          <= 1'b0;
            rsp_busy_ff         <= 1'b0;
            rsp_result_valid_ff <= 1'b1;
            rsp_is_tare_ff      <= run_is_tare_ff;
            rsp_value_ff        <= final_value;
            state_ff            <= ST_IDLE;
            if (run_is_tare_ff) begin
               if (use_a_ff) begin
                  offset_a_ff <= tare_value;
               end else begin
                  offset_b_ff <= tare_value;
               end
            end
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sck_level      = rsp_sck_ff;
   assign rsp_busy_res       = rsp_busy_ff;
   assign rsp_result_valid   = rsp_result_valid_ff;
   assign rsp_result_is_tare = rsp_is_tare_ff;
   assign rsp_result_value   = $signed(rsp_value_ff);

`ifndef ASSERT_OFF
   a_no_req_while_divide: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> !req_ready)
      else $error("request taken while the divide is running");

   a_divide_gives_response: assert property (@(posedge clock) disable iff (reset)
      div_done |=> rsp_valid && rsp_result_valid && !rsp_busy_res)
      else $error("divide finished without a finishing response");

   a_result_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_valid |-> !rsp_busy_res && !rsp_sck_level)
      else $error("finishing response reports a busy run or a high clock");

   a_quiet_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_valid |-> rsp_result_value == '0 && !rsp_result_is_tare)
      else $error("result fields set on a tick without a result");
`endif

endmodule

[sim/tb_load_cell_adc_reader.sv]
// Self-checking testbench for the load-cell converter readout block, with a tick-level predictor.
`timescale 1ns / 1ps

module tb_load_cell_adc_reader;
   import lcar_pkg::*;

   localparam int CYCLE_LIMIT     = 500000;
   localparam int RANDOM_TICKS    = 300;
   localparam int RSP_HOLD_CYCLES = 200;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE, ST_WAIT, ST_DATA_HI, ST_DATA_LO, ST_GAIN_HI, ST_GAIN_LO
   } readout_phase_type;

   typedef enum int {
      PAT_RANDOM, PAT_ALL_ONES, PAT_ALL_ZEROS, PAT_FULL_SCALE, PAT_ZERO_SCALE
   } sample_pattern_type;

   typedef struct packed {
      logic                      sck;
      logic                      busy;
      logic                      done;
      logic                      is_tare;
      logic signed [VALUE_W-1:0] value;
   } tick_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OP_W-1:0]           req_operation = OP_TICK;
   logic                      req_dout_level = 1'b1;
   logic [OFS_W-1:0]          req_offset_value = '0;
   logic                      req_offset_select = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_sck_level;
   logic                      rsp_busy_res;
   logic                      rsp_result_valid;
   logic                      rsp_result_is_tare;
   logic signed [VALUE_W-1:0] rsp_result_value;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   // Predictor state, mirroring the block after reset.
   readout_phase_type      lc_phase = ST_IDLE;
   logic [PULSE_W-1:0]     lc_pulses = '0;
   logic [SAMPLE_BITS-1:0] lc_shift = '0;
   logic [63:0]            lc_sum = '0;
   logic [COUNT_W-1:0]     lc_reads = '0;
   logic                   lc_tare_run = 1'b0;
   logic [OFS_W-1:0]       lc_ofs_a = '0;
   logic [OFS_W-1:0]       lc_ofs_b = '0;
   logic [GAIN_W-1:0]      cfg_gain = 2'd1;
   logic [COUNT_W-1:0]     cfg_count = 8'd1;

   tick_result_type awaited_ticks[$];
   bit no_idle = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int cycle_count = 0;
   int ticks_sent = 0;
   int ticks_checked = 0;
   int runs_finished = 0;
   int csr_writes = 0;
   int mismatches = 0;

   load_cell_adc_reader dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timed out with %0d ticks still awaited", $time, awaited_ticks.size());
      $display("load_cell_adc_reader: mismatch");
      $finish;
   end

   function automatic logic [GAIN_W-1:0] gain_in_use();
      return (cfg_gain == '0) ? 2'd1 : cfg_gain;
   endfunction

   function automatic logic [COUNT_W-1:0] count_in_use();
      return (cfg_count == '0) ? 8'd1 : cfg_count;
   endfunction

   // Advances the predicted pin sequencer by one tick and returns what the block reports.
   function automatic tick_result_type readout_step(logic [OP_W-1:0] op, logic dout,
         logic [OFS_W-1:0] ofs_val, logic ofs_sel);
      tick_result_type o;
      logic [63:0] avg;
      logic [63:0] ofs;
      logic [63:0] diff;
      logic [OFS_W-1:0] stored;
      logic use_a;
      o = '0;
      case (lc_phase)
         ST_IDLE: begin
            if (op == OP_MEASURE || op == OP_TARE) begin
               lc_tare_run = (op == OP_TARE);
               lc_sum = '0;
               lc_reads = '0;
               lc_pulses = '0;
               lc_phase = ST_WAIT;
            end else if (op == OP_SET_OFFSET) begin
               if (ofs_sel) lc_ofs_b = ofs_val;
               else lc_ofs_a = ofs_val;
            end
         end
         ST_WAIT: begin
            if (!dout) begin
               lc_pulses = '0;
               lc_shift = '0;
               lc_phase = ST_DATA_HI;
            end
         end
         ST_DATA_HI: begin
            o.sck = 1'b1;
            lc_shift = {lc_shift[SAMPLE_BITS-2:0], dout};
            lc_pulses = lc_pulses + 1'b1;
            lc_phase = ST_DATA_LO;
         end
         ST_DATA_LO: begin
            if (lc_pulses >= SAMPLE_BITS) begin
               lc_pulses = '0;
               lc_phase = ST_GAIN_HI;
            end else begin
               lc_phase = ST_DATA_HI;
            end
         end
         ST_GAIN_HI: begin
            o.sck = 1'b1;
            lc_pulses = lc_pulses + 1'b1;
            lc_phase = ST_GAIN_LO;
         end
         default: begin
            if (lc_pulses < gain_in_use()) begin
               lc_phase = ST_GAIN_HI;
            end else begin
               lc_pulses = '0;
               lc_sum = lc_sum + (lc_shift ^ SIGN_FLIP);
               lc_reads = lc_reads + 1'b1;
               if (lc_reads == '0) lc_reads = 8'd1;
               if (lc_reads >= count_in_use()) begin
                  avg = lc_sum / lc_reads;
                  use_a = (gain_in_use() == GAIN_CHANNEL_A64);
                  o.done = 1'b1;
                  o.is_tare = lc_tare_run;
                  if (lc_tare_run) begin
                     stored = (avg > OFS_MAX) ? OFS_MAX : avg[OFS_W-1:0];
                     if (use_a) lc_ofs_a = stored;
                     else lc_ofs_b = stored;
                     o.value = {1'b0, stored};
                  end else begin
                     ofs = use_a ? lc_ofs_a : lc_ofs_b;
                     if (avg >= ofs) begin
                        diff = avg - ofs;
                        o.value = (diff > OFS_MAX) ? {1'b0, OFS_MAX} : diff[VALUE_W-1:0];
                     end else begin
                        diff = 64'd0 - (ofs - avg);
                        o.value = diff[VALUE_W-1:0];
                     end
                  end
                  lc_phase = ST_IDLE;
               end else begin
                  lc_phase = ST_WAIT;
               end
            end
         end
      endcase
      o.busy = (lc_phase != ST_IDLE);
      return o;
   endfunction

   // Receiver: random stalls, plus a long hold-off when a test asks for one.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = RSP_HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 10);
      end
   end

   function automatic void check_field(string name, logic [VALUE_W-1:0] want,
         logic [VALUE_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      tick_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_ticks.size() == 0) begin
            mismatches++;
            $display("%0t: response transfer with nothing awaited", $time);
         end else begin
            want = awaited_ticks.pop_front();
            check_field("sck_level", want.sck, rsp_sck_level);
            check_field("busy_res", want.busy, rsp_busy_res);
            check_field("result_valid", want.done, rsp_result_valid);
            check_field("result_is_tare", want.is_tare, rsp_result_is_tare);
            check_field("result_value", want.value, rsp_result_value);
            ticks_checked++;
            if (want.done) runs_finished++;
         end
      end
   end

   task automatic send_tick(input logic [OP_W-1:0] op, input logic dout,
         input logic [OFS_W-1:0] ofs_val, input logic ofs_sel);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_dout_level <= dout;
      req_offset_value <= ofs_val;
      req_offset_select <= ofs_sel;
      do @(posedge clock); while (!req_ready);
      awaited_ticks.push_back(readout_step(op, dout, ofs_val, ofs_sel));
      ticks_sent++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
         input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_GAIN_PULSES) cfg_gain = data[GAIN_W-1:0];
      else if (idx == CSR_AVERAGE_COUNT) cfg_count = data;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stops offering ticks and waits until every response has been checked.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_ticks.size() != 0) @(posedge clock);
      repeat (SUM_W + 4) @(posedge clock);
   endtask

   // Issues one operation and then plays the converter until the run is over.
   // The data pin follows the pattern on high data ticks and is random elsewhere.
   task automatic run_conversions(input logic [OP_W-1:0] op,
         input sample_pattern_type pattern, input int wait_max, input bit noisy);
      logic [SAMPLE_BITS-1:0] raw_word;
      logic dout;
      logic [OP_W-1:0] busy_op;
      raw_word = '0;
      send_tick(op, 1'($urandom_range(1)), OFS_W'($urandom()), 1'($urandom_range(1)));
      while (lc_phase != ST_IDLE) begin
         dout = 1'($urandom_range(1));
         if (lc_phase == ST_WAIT) begin
            dout = ($urandom_range(wait_max) != 0);
            if (!dout) begin
               case (pattern)
                  PAT_ALL_ONES:   raw_word = '1;
                  PAT_ALL_ZEROS:  raw_word = '0;
                  PAT_FULL_SCALE: raw_word = ~SIGN_FLIP;
                  PAT_ZERO_SCALE: raw_word = SIGN_FLIP;
                  default:        raw_word = SAMPLE_BITS'($urandom());
               endcase
            end
         end else if (lc_phase == ST_DATA_HI) begin
            dout = raw_word[SAMPLE_BITS - 1 - lc_pulses];
         end
         busy_op = noisy ? OP_W'($urandom_range(3)) : OP_TICK;
         send_tick(busy_op, dout, OFS_W'($urandom()), 1'($urandom_range(1)));
      end
   endtask

   task automatic test_offset_registers();
      send_tick(OP_SET_OFFSET, 1'b1, 24'hFFFFFF, 1'b0);
      send_tick(OP_SET_OFFSET, 1'b0, 24'h000000, 1'b1);
      send_tick(OP_TICK, 1'b0, 24'h555555, 1'b1);
      send_tick(OP_TICK, 1'b1, 24'hAAAAAA, 1'b0);
      wait_drained();
   endtask

   task automatic test_gain_channels();
      // Offset A holds full scale, so a zero reading on channel A gives the most negative value.
      write_csr(CSR_GAIN_PULSES, 8'd3);
      run_conversions(OP_MEASURE, PAT_ZERO_SCALE, 2, 1'b0);
      wait_drained();
      write_csr(CSR_GAIN_PULSES, 8'd1);
      run_conversions(OP_MEASURE, PAT_FULL_SCALE, 0, 1'b0);
      wait_drained();
      write_csr(CSR_GAIN_PULSES, 8'd2);
      run_conversions(OP_TARE, PAT_RANDOM, 3, 1'b0);
      run_conversions(OP_MEASURE, PAT_RANDOM, 3, 1'b0);
      wait_drained();
      write_csr(CSR_GAIN_PULSES, 8'd3);
      run_conversions(OP_TARE, PAT_ALL_ONES, 1, 1'b0);
      run_conversions(OP_MEASURE, PAT_ALL_ZEROS, 1, 1'b0);
      wait_drained();
      write_csr(CSR_AVERAGE_COUNT, 8'd4);
      run_conversions(OP_MEASURE, PAT_RANDOM, 2, 1'b0);
      wait_drained();
   endtask

   task automatic test_ops_while_busy();
      write_csr(CSR_GAIN_PULSES, 8'd1);
      write_csr(CSR_AVERAGE_COUNT, 8'd2);
      run_conversions(OP_TARE, PAT_RANDOM, 8, 1'b1);
      run_conversions(OP_MEASURE, PAT_RANDOM, 8, 1'b1);
      wait_drained();
   endtask

   task automatic test_zero_registers();
      // Upper data bits are dropped, so this selects zero gain pulses.
      write_csr(CSR_GAIN_PULSES, 8'hFC);
      write_csr(CSR_AVERAGE_COUNT, 8'd0);
      write_csr(CSR_SPARE_LO, 8'hFF);
      write_csr(CSR_SPARE_HI, 8'h5A);
      run_conversions(OP_TARE, PAT_RANDOM, 2, 1'b0);
      run_conversions(OP_MEASURE, PAT_RANDOM, 2, 1'b1);
      wait_drained();
   endtask

   task automatic test_deep_average();
      no_idle = 1'b1;
      write_csr(CSR_GAIN_PULSES, 8'd1);
      write_csr(CSR_AVERAGE_COUNT, 8'd7);
      run_conversions(OP_MEASURE, PAT_FULL_SCALE, 0, 1'b0);
      wait_drained();
      no_idle = 1'b0;
   endtask

   task automatic test_output_backpressure();
      write_csr(CSR_GAIN_PULSES, CSR_DATA_W'($urandom_range(3, 1)));
      write_csr(CSR_AVERAGE_COUNT, 8'd2);
      hold_request = 1'b1;
      run_conversions(OP_MEASURE, PAT_RANDOM, 3, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int start_ticks;
      int r;
      start_ticks = ticks_sent;
      while (ticks_sent - start_ticks < RANDOM_TICKS) begin
         write_csr(CSR_GAIN_PULSES, CSR_DATA_W'($urandom_range(255)));
         r = $urandom_range(99);
         write_csr(CSR_AVERAGE_COUNT,
                   CSR_DATA_W'((r < 10) ? 0 : (r < 85) ? $urandom_range(3, 1)
                                                       : $urandom_range(8, 4)));
         repeat ($urandom_range(8, 3)) begin
            r = $urandom_range(99);
            if (r < 60)
               run_conversions($urandom_range(1) ? OP_TARE : OP_MEASURE,
                               ($urandom_range(4) == 0) ? sample_pattern_type'($urandom_range(4))
                                                        : PAT_RANDOM,
                               $urandom_range(6), 1'($urandom_range(1)));
            else if (r < 78)
               send_tick(OP_SET_OFFSET, 1'($urandom_range(1)), OFS_W'($urandom()),
                         1'($urandom_range(1)));
            else if (r < 90)
               repeat ($urandom_range(5, 1))
                  send_tick(OP_TICK, 1'($urandom_range(1)), OFS_W'($urandom()),
                            1'($urandom_range(1)));
            else
               run_conversions(OP_W'($urandom_range(3)), PAT_RANDOM, $urandom_range(12), 1'b1);
         end
         wait_drained();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_offset_registers();
      test_gain_channels();
      test_ops_while_busy();
      test_zero_registers();
      test_deep_average();
      test_output_backpressure();
      test_random_traffic();
      wait_drained();
      $display("Ran %0d ticks, checked %0d responses, %0d finished measure or tare runs.",
               ticks_sent, ticks_checked, runs_finished);
      $display("Made %0d register writes; %0d field mismatches seen.", csr_writes, mismatches);
      if (mismatches == 0)
         $display("load_cell_adc_reader: match");
      else
         $display("load_cell_adc_reader: mismatch");
      $finish;
   end

endmodule
